// ===== rtl/multiset_bag_table_top_defines.svh =====
// assertion macros for the bag table block
// included by the top level, no other dependencies
`ifndef MULTISET_BAG_TABLE_TOP_DEFINES_SVH
`define MULTISET_BAG_TABLE_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define MBT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bag table check failed");

// next-cycle implication, held off during reset
`define MBT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bag table check failed");

`endif

// ===== rtl/mbt_pkg.sv =====
// shared types and codes for the bag table block
// no dependencies
package mbt_pkg;

    // request kinds
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OP_W-1:0] OP_CONTAINS = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

    // port widths
    localparam int IN_VALUE_W  = 32;
    localparam int COUNT_W     = 5;
    localparam int OUT_TDATA_W = 8;

    // one answer from the sequencer
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } res_t;

endpackage

// ===== rtl/mbt_store.sv =====
// entry memory: one write port, one read port with registered data
// no dependencies
module mbt_store #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mbt_seq.sv =====
// request sequencer with the shared entry comparator
// depends on mbt_pkg, drives the mbt_store ports
module mbt_seq #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32,
    parameter int ADDR_W     = 4,
    parameter int CNT_W      = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [mbt_pkg::OP_W-1:0] in_op,
    input  logic [VALUE_BITS-1:0]   in_value,
    output logic                    res_valid,
    input  logic                    res_ready,
    output mbt_pkg::res_t           res,
    output logic                    mem_we,
    output logic [ADDR_W-1:0]       mem_waddr,
    output logic [VALUE_BITS-1:0]   mem_wdata,
    output logic [ADDR_W-1:0]       mem_raddr,
    input  logic [VALUE_BITS-1:0]   mem_rdata
);

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
    localparam logic [ST_W-1:0] ST_SCAN = 2'd1;
    localparam logic [ST_W-1:0] ST_MOVE = 2'd2;
    localparam logic [ST_W-1:0] ST_RESP = 2'd3;

    logic [ST_W-1:0]          state_reg, state_next;
    logic [mbt_pkg::OP_W-1:0] op_reg, op_next;
    logic [VALUE_BITS-1:0]    val_reg, val_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]         held_reg, held_next;
    logic                     ok_reg, ok_next;

    logic [CNT_W-1:0]         held_m1;
    logic [ADDR_W-1:0]        idx_step;
    logic                     match;
    logic                     last;
    logic [CNT_W+mbt_pkg::COUNT_W-1:0] held_ext;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    // request payload
    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        ok_reg  <= ok_next;
    end

    // shared comparator and scan pointer arithmetic
    always_comb begin
        held_m1  = held_reg - CNT_W'(1);
        match    = (mem_rdata == val_reg);
        if (op_reg == mbt_pkg::OP_REMOVE) begin
            last     = (idx_reg == '0);
            idx_step = idx_reg - ADDR_W'(1);
        end else begin
            last     = (CNT_W'(idx_reg) == held_m1);
            idx_step = idx_reg + ADDR_W'(1);
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        held_next  = held_reg;
        ok_next    = ok_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = val_reg;
        mem_raddr  = idx_reg;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next  = in_op;
                    val_next = in_value;
                    ok_next  = 1'b0;
                    unique case (in_op)
                        mbt_pkg::OP_ADD: begin
                            if (held_reg < CNT_W'(CAPACITY)) begin
                                mem_we    = 1'b1;
                                mem_waddr = held_reg[ADDR_W-1:0];
                                mem_wdata = in_value;
                                held_next = held_reg + CNT_W'(1);
                                ok_next   = 1'b1;
                            end
                            state_next = ST_RESP;
                        end
                        mbt_pkg::OP_REMOVE: begin
                            // newest entry first
                            idx_next  = held_m1[ADDR_W-1:0];
                            mem_raddr = held_m1[ADDR_W-1:0];
                            state_next = (held_reg == '0) ? ST_RESP : ST_SCAN;
                        end
                        mbt_pkg::OP_CONTAINS: begin
                            idx_next  = '0;
                            mem_raddr = '0;
                            state_next = (held_reg == '0) ? ST_RESP : ST_SCAN;
                        end
                        mbt_pkg::OP_CLEAR: begin
                            held_next  = '0;
                            ok_next    = 1'b1;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (match) begin
                    if (op_reg == mbt_pkg::OP_CONTAINS) begin
                        ok_next    = 1'b1;
                        state_next = ST_RESP;
                    end else if (CNT_W'(idx_reg) == held_m1) begin
                        // match is the newest entry: just drop it
                        held_next  = held_m1;
                        ok_next    = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        // fetch the newest entry to fill the hole
                        mem_raddr  = held_m1[ADDR_W-1:0];
                        state_next = ST_MOVE;
                    end
                end else if (last) begin
                    state_next = ST_RESP;
                end else begin
                    idx_next  = idx_step;
                    mem_raddr = idx_step;
                end
            end
            ST_MOVE: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = mem_rdata;
                held_next  = held_m1;
                ok_next    = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // answer word, count keeps the low bits of the entry count
    assign held_ext  = {{mbt_pkg::COUNT_W{1'b0}}, held_reg};
    assign res.ok    = ok_reg;
    assign res.count = held_ext[mbt_pkg::COUNT_W-1:0];
    assign res.empty = (held_reg == '0);

endmodule

// ===== rtl/multiset_bag_table_top.sv =====
// add and clear go from accept straight to the answer state; contains and remove
// first scan the entries compared (at most CAPACITY), remove with a fill from
// the newest slot also passes the move state; one comparator checks one entry a cycle
// a new word is taken once the previous result is handed to the output register
// reset: aresetn synchronous active low, empties the store, no clearing pass
module multiset_bag_table_top #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mbt_pkg::IN_VALUE_W-1:0]  s_tdata,   // value[31:0]
    input  logic [mbt_pkg::OP_W-1:0]        s_tuser,   // op[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mbt_pkg::OUT_TDATA_W-1:0] m_tdata    // ok[0], count[5:1], empty_res[6], zero[7]
);

`include "multiset_bag_table_top_defines.svh"

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [mbt_pkg::IN_VALUE_W+VALUE_BITS-1:0] value_ext;
    logic [VALUE_BITS-1:0]  value;
    logic                   res_valid;
    logic                   res_ready;
    mbt_pkg::res_t          res;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_BITS-1:0]  mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [VALUE_BITS-1:0]  mem_rdata;
    logic                   m_tvalid_reg;
    logic [mbt_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // sign-extend the input value, keep the stored width
    assign value_ext = {{VALUE_BITS{s_tdata[mbt_pkg::IN_VALUE_W-1]}}, s_tdata};
    assign value     = value_ext[VALUE_BITS-1:0];

    mbt_seq #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    mbt_store #(
        .DEPTH  (CAPACITY),
        .WIDTH  (VALUE_BITS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {1'b0, res.empty, res.count, res.ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a taken word closes the input in the cycle after it is taken
    `MBT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a blocked answer stays offered until the output register frees
    `MBT_ASSERT_NEXT(a_res_held, aclk, aresetn, res_valid && !res_ready, res_valid)
    // an empty store always reports a zero count
    `MBT_ASSERT_NOW(a_empty_count, aclk, aresetn, m_tvalid && m_tdata[6], m_tdata[5:1] == 5'd0)

endmodule

// ===== dv/mbt_checker.sv =====
// bag table checker: watches both stream channels, predicts each answer and compares
// depends on mbt_pkg for request codes and the answer layout
module mbt_checker #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mbt_pkg::IN_VALUE_W-1:0]  s_tdata,   // value[31:0]
    input  logic [mbt_pkg::OP_W-1:0]        s_tuser,   // op[1:0]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mbt_pkg::OUT_TDATA_W-1:0] m_tdata,   // ok[0], count[5:1], empty_res[6], zero[7]
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    // own copy of the bag contents
    logic [VALUE_BITS-1:0] bag_slots [CAPACITY];
    int                    bag_held;

    // answers still owed by the block, oldest first
    mbt_pkg::res_t expected_answers [$];
    int            fail_cnt;

    initial begin
        errors   = 0;
        pending  = 0;
        fail_cnt = 0;
        bag_held = 0;
    end

    // apply one request to the bag and return the answer it should give
    function automatic mbt_pkg::res_t apply_request(
        input logic [mbt_pkg::OP_W-1:0]       op,
        input logic [mbt_pkg::IN_VALUE_W-1:0] value
    );
        logic [VALUE_BITS-1:0] key;
        logic                  hit;
        int                    i;
        mbt_pkg::res_t         ans;
        key = VALUE_BITS'($signed(value));
        hit = 1'b0;
        case (op)
            mbt_pkg::OP_ADD: begin
                if (bag_held < CAPACITY) begin
                    bag_slots[bag_held] = key;
                    bag_held++;
                    hit = 1'b1;
                end
            end
            mbt_pkg::OP_REMOVE: begin
                // newest match goes, its slot refilled from the newest entry
                for (i = bag_held; i > 0; i--) begin
                    if (bag_slots[i-1] == key) begin
                        bag_slots[i-1] = bag_slots[bag_held-1];
                        bag_held--;
                        hit = 1'b1;
                        break;
                    end
                end
            end
            mbt_pkg::OP_CONTAINS: begin
                for (i = 0; i < bag_held; i++) begin
                    if (bag_slots[i] == key) begin
                        hit = 1'b1;
                        break;
                    end
                end
            end
            default: begin
                bag_held = 0;
                hit      = 1'b1;
            end
        endcase
        ans.ok    = hit;
        ans.count = mbt_pkg::COUNT_W'(bag_held);
        ans.empty = (bag_held == 0);
        return ans;
    endfunction

    // answers are retired before new words are predicted, since no answer leaves in the same cycle as its request
    always @(posedge aclk) begin : watch
        mbt_pkg::res_t want;
        if (!aresetn) begin
            bag_held = 0;
            expected_answers.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("unexpected answer word %h at %t", m_tdata, $realtime);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_tdata[0] !== want.ok || m_tdata[5:1] !== want.count ||
                        m_tdata[6] !== want.empty || m_tdata[7] !== 1'b0) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display({"answer mismatch at %t: ",
                                      "expected ok=%0d count=%0d empty=%0d pad=0, ",
                                      "got ok=%0d count=%0d empty=%0d pad=%0d"},
                                     $realtime, want.ok, want.count, want.empty,
                                     m_tdata[0], m_tdata[5:1], m_tdata[6], m_tdata[7]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_answers.push_back(apply_request(s_tuser, s_tdata));
        end
        errors  <= fail_cnt;
        pending <= expected_answers.size();
    end

endmodule

// ===== dv/tb.sv =====
// bag table testbench top: clock, reset, request stimulus, answer back-pressure, verdict
// depends on mbt_pkg, multiset_bag_table_top and mbt_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 750;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 40;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mbt_pkg::IN_VALUE_W-1:0]  s_tdata  = '0;               // value[31:0]
    logic [mbt_pkg::OP_W-1:0]        s_tuser  = mbt_pkg::OP_ADD;  // op[1:0]
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mbt_pkg::OUT_TDATA_W-1:0] m_tdata;  // ok[0], count[5:1], empty_res[6], zero[7]

    int errors;
    int pending;
    int answers_seen = 0;
    int idle_cycles  = 0;

    // value pool so that removes and lookups find something
    logic [mbt_pkg::IN_VALUE_W-1:0] pool [8];
    int                             pool_n;

    multiset_bag_table_top #(
        .CAPACITY   (16),
        .VALUE_BITS (32)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mbt_checker #(
        .CAPACITY   (16),
        .VALUE_BITS (32)
    ) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // clock
    always #5 aclk = ~aclk;

    // answer words taken, used to time the long receiver hold-offs
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            answers_seen <= answers_seen + 1;
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[multiset_bag_table_top] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one request word and hold it until taken
    task automatic push_request(input logic [mbt_pkg::OP_W-1:0]       op,
                                input logic [mbt_pkg::IN_VALUE_W-1:0] value,
                                input int                             gap);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering and wait for every owed answer
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // new pool of values, extremes mixed in now and then
    task automatic refresh_pool();
        int i;
        pool_n = $urandom_range(1, 8);
        for (i = 0; i < 8; i++) begin
            case ($urandom_range(0, 19))
                0:       pool[i] = 32'h0000_0000;
                1:       pool[i] = 32'hFFFF_FFFF;
                2:       pool[i] = 32'h8000_0000;
                3:       pool[i] = 32'h7FFF_FFFF;
                default: pool[i] = $urandom;
            endcase
        end
    endtask

    // receiver: bursts of ready, short and long stalls, two long hold-offs
    initial begin : receiver
        int holds_left;
        int hold_at;
        int r;
        holds_left = 2;
        hold_at    = 150;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (holds_left > 0 && answers_seen >= hold_at) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_left--;
                hold_at = answers_seen + 350;
            end else if (r < 15) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_tready <= 1'b0;
                if (r < 90)
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                else
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int                             sent;
        int                             ep_len;
        int                             ep_kind;
        int                             w_add;
        int                             w_rem;
        int                             w_has;
        int                             r;
        int                             i;
        logic                           burst;
        logic [mbt_pkg::OP_W-1:0]       op;
        logic [mbt_pkg::IN_VALUE_W-1:0] value;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store: clear, remove and lookup find nothing
        push_request(mbt_pkg::OP_CLEAR,    32'h0000_0000, pick_gap());
        push_request(mbt_pkg::OP_REMOVE,   32'h0000_0000, pick_gap());
        push_request(mbt_pkg::OP_CONTAINS, 32'hFFFF_FFFF, pick_gap());
        // value extremes plus a duplicate
        push_request(mbt_pkg::OP_ADD, 32'h0000_0000, pick_gap());
        push_request(mbt_pkg::OP_ADD, 32'hFFFF_FFFF, pick_gap());
        push_request(mbt_pkg::OP_ADD, 32'h8000_0000, pick_gap());
        push_request(mbt_pkg::OP_ADD, 32'h7FFF_FFFF, pick_gap());
        push_request(mbt_pkg::OP_ADD, 32'hFFFF_FFFF, pick_gap());
        push_request(mbt_pkg::OP_CONTAINS, 32'h7FFF_FFFF, pick_gap());
        push_request(mbt_pkg::OP_CONTAINS, 32'h1234_5678, pick_gap());
        // duplicate: only the newest copy goes, the older one stays
        push_request(mbt_pkg::OP_REMOVE,   32'hFFFF_FFFF, pick_gap());
        push_request(mbt_pkg::OP_CONTAINS, 32'hFFFF_FFFF, pick_gap());
        push_request(mbt_pkg::OP_REMOVE,   32'h1234_5678, pick_gap());
        // oldest entry removed, slot refilled from the newest
        push_request(mbt_pkg::OP_REMOVE,   32'h0000_0000, pick_gap());
        // fill to capacity, then one add too many
        for (i = 0; i < 13; i++)
            push_request(mbt_pkg::OP_ADD, $urandom, pick_gap());
        push_request(mbt_pkg::OP_ADD,      32'h5555_AAAA, pick_gap());
        push_request(mbt_pkg::OP_CONTAINS, 32'h8000_0000, pick_gap());
        push_request(mbt_pkg::OP_REMOVE,   32'h7FFF_FFFF, pick_gap());
        push_request(mbt_pkg::OP_CLEAR,    32'hFFFF_FFFF, pick_gap());
        drain_answers();

        // random episodes: filling, draining or mixed, values mostly from a pool
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            refresh_pool();
            ep_kind = $urandom_range(0, 2);
            ep_len  = $urandom_range(8, 60);
            burst   = ($urandom_range(0, 3) == 0);
            case (ep_kind)
                0:       begin w_add = 65; w_rem = 80; w_has = 97; end
                1:       begin w_add = 20; w_rem = 70; w_has = 97; end
                default: begin w_add = 35; w_rem = 65; w_has = 97; end
            endcase
            for (i = 0; i < ep_len && sent < RANDOM_WORDS; i++) begin
                r = $urandom_range(0, 99);
                if (r < w_add)
                    op = mbt_pkg::OP_ADD;
                else if (r < w_rem)
                    op = mbt_pkg::OP_REMOVE;
                else if (r < w_has)
                    op = mbt_pkg::OP_CONTAINS;
                else
                    op = mbt_pkg::OP_CLEAR;
                if ($urandom_range(0, 99) < 85)
                    value = pool[$urandom_range(0, pool_n - 1)];
                else
                    value = $urandom;
                push_request(op, value, burst ? 0 : pick_gap());
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                drain_answers();
        end

        // wait out the owed answers, then a tail for anything stray
        drain_answers();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("[multiset_bag_table_top] OK");
        else
            $display("[multiset_bag_table_top] ERROR");
        $finish;
    end

endmodule

// ===== multiset_bag_table_top.f =====
+incdir+rtl
rtl/mbt_pkg.sv
rtl/mbt_store.sv
rtl/mbt_seq.sv
rtl/multiset_bag_table_top.sv
dv/mbt_checker.sv
dv/tb.sv
